/* sv/hexapod_leg_phase_force_feedback_top_macros.svh */
// Assertion macros shared by the leg phase and force feedback block
`ifndef HEXAPOD_LEG_PHASE_FORCE_FEEDBACK_TOP_MACROS_SVH
`define HEXAPOD_LEG_PHASE_FORCE_FEEDBACK_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define HLPFF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define HLPFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hlpff_pkg.sv */
// Types, constants and helper functions of the leg phase and force feedback block
`timescale 1ns / 1ps

package hlpff_pkg;

    localparam int DELAY_DEPTH  = 256;
    localparam int SAMPLE_WIDTH = 16;
    localparam int NUM_LEGS     = 6;
    localparam int DATA_W       = 16;
    localparam int KEEP_W       = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
    localparam int PTR_W        = $clog2(DELAY_DEPTH);
    localparam int DLY_W        = 8;
    localparam int SUM_W        = ((PTR_W > DLY_W) ? PTR_W : DLY_W) + 1;
    localparam int HW           = DATA_W + 2;
    localparam int CFG_IDX_W    = 2;

    localparam int LEG_DELAY_W  = 6;
    localparam int SIDE_DELAY_W = 7;

    typedef logic signed [DATA_W-1:0] q14_t;
    typedef logic signed [HW-1:0]     hwide_t;

    localparam hwide_t ONE_Q14      = 18'sd16384;
    localparam hwide_t STEP_BIG     = 18'sd983;
    localparam hwide_t STEP_SMALL   = 18'sd328;
    localparam hwide_t HEIGHT_LIMIT = 18'sd8192;

    localparam logic [LEG_DELAY_W-1:0]  LEG_DELAY_RST  = 6'd18;
    localparam logic [SIDE_DELAY_W-1:0] SIDE_DELAY_RST = 7'd90;
    localparam q14_t                    FORCE_LOW_RST  = 16'sd3277;
    localparam q14_t                    FORCE_HIGH_RST = 16'sd9830;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEG_DELAY  = 2'd0,
        CFG_SIDE_DELAY = 2'd1,
        CFG_FORCE_LOW  = 2'd2,
        CFG_FORCE_HIGH = 2'd3
    } cfg_reg_e;

    // How a leg builds its phase from the ring read
    typedef struct packed {
        logic bypass;   // zero delay: take the fresh sample
        logic written;  // ring entry has been written since reset
    } tap_sel_t;

    function automatic q14_t sext_sample(input logic [KEEP_W-1:0] x);
        logic signed [KEEP_W-1:0] v;
        v = signed'(x);
        return q14_t'(v);
    endfunction

    // Fold a delay into the ring depth (delays stay below twice the depth)
    function automatic logic [SUM_W-1:0] tap_fold(input logic [DLY_W-1:0] d);
        logic [SUM_W-1:0] dx;
        dx = SUM_W'(d);
        if (dx >= SUM_W'(DELAY_DEPTH))
            return dx - SUM_W'(DELAY_DEPTH);
        return dx;
    endfunction

    function automatic logic [PTR_W-1:0] tap_index(input logic [PTR_W-1:0] wp,
                                                   input logic [SUM_W-1:0] dm);
        logic [SUM_W-1:0] s;
        s = SUM_W'(wp) + SUM_W'(DELAY_DEPTH) - dm;
        if (s >= SUM_W'(DELAY_DEPTH))
            s = s - SUM_W'(DELAY_DEPTH);
        return s[PTR_W-1:0];
    endfunction

endpackage

/* sv/hlpff_if.sv */
// Handshake interfaces for the tick input and the leg target output
`timescale 1ns / 1ps

interface hlpff_in_if;
    import hlpff_pkg::*;

    logic valid;
    logic ready;
    q14_t cpg_sample;
    q14_t force_r0;
    q14_t force_r1;
    q14_t force_r2;
    q14_t force_l0;
    q14_t force_l1;
    q14_t force_l2;

    modport source (
        output valid, cpg_sample, force_r0, force_r1, force_r2,
               force_l0, force_l1, force_l2,
        input  ready
    );
    modport sink (
        input  valid, cpg_sample, force_r0, force_r1, force_r2,
               force_l0, force_l1, force_l2,
        output ready
    );
endinterface

interface hlpff_out_if;
    import hlpff_pkg::*;

    logic valid;
    logic ready;
    q14_t phase_r0;
    q14_t phase_r1;
    q14_t phase_r2;
    q14_t phase_l0;
    q14_t phase_l1;
    q14_t phase_l2;
    q14_t height_r0;
    q14_t height_r1;
    q14_t height_r2;
    q14_t height_l0;
    q14_t height_l1;
    q14_t height_l2;

    modport source (
        output valid, phase_r0, phase_r1, phase_r2, phase_l0, phase_l1, phase_l2,
               height_r0, height_r1, height_r2, height_l0, height_l1, height_l2,
        input  ready
    );
    modport sink (
        input  valid, phase_r0, phase_r1, phase_r2, phase_l0, phase_l1, phase_l2,
               height_r0, height_r1, height_r2, height_l0, height_l1, height_l2,
        output ready
    );
endinterface

/* sv/hlpff_tap_ram.sv */
// One delay ring copy: one write port, one registered read port
`timescale 1ns / 1ps

module hlpff_tap_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [hlpff_pkg::PTR_W-1:0]  waddr,
    input  logic [hlpff_pkg::KEEP_W-1:0] wdata,
    input  logic                         re,
    input  logic [hlpff_pkg::PTR_W-1:0]  raddr,
    output logic [hlpff_pkg::KEEP_W-1:0] rdata
);
    import hlpff_pkg::*;

    logic [KEEP_W-1:0] mem [DELAY_DEPTH];
    logic [KEEP_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/hlpff_leg.sv */
// One leg: phase select, swing/support decision and force rules on height
`timescale 1ns / 1ps

module hlpff_leg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  hlpff_pkg::tap_sel_t          sel,
    input  logic [hlpff_pkg::KEEP_W-1:0] ram_q,
    input  hlpff_pkg::q14_t              fresh,
    input  hlpff_pkg::q14_t              force_in,
    input  hlpff_pkg::q14_t              force_low,
    input  hlpff_pkg::q14_t              force_high,
    output hlpff_pkg::q14_t              phase,
    output hlpff_pkg::q14_t              height
);
    import hlpff_pkg::*;

    q14_t   phase_reg;
    q14_t   height_reg;
    q14_t   phase_next;
    q14_t   height_next;
    logic   rising;
    hwide_t pw;
    hwide_t hx;
    hwide_t z;

    always_comb
    begin
        if (sel.bypass)
            phase_next = fresh;
        else if (sel.written)
            phase_next = sext_sample(ram_q);
        else
            phase_next = '0;
    end

    assign rising = phase_next > phase_reg;
    assign pw     = hwide_t'(phase_next);
    assign hx     = hwide_t'(height_reg);

    // Later force rules override earlier ones; a rising negative phase overrides them all
    always_comb
    begin
        if (rising && phase_next < 0)
        begin
            z = pw + ONE_Q14;
        end
        else
        begin
            z = rising ? (ONE_Q14 - pw) : '0;
            if (force_in < force_low)
                z = hx - STEP_BIG;
            if (force_in >= force_low && force_in <= force_high && hx <= 0)
                z = hx;
            if (force_in > force_high && hx <= 0)
                z = hx + STEP_SMALL;
            if (force_in >= force_low && hx > 0)
                z = hx - STEP_SMALL;
            if (z < -HEIGHT_LIMIT)
                z = -HEIGHT_LIMIT;
            else if (z > HEIGHT_LIMIT)
                z = HEIGHT_LIMIT;
        end
        height_next = z[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            height_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            height_reg <= height_next;
        end
    end

    assign phase  = phase_reg;
    assign height = height_reg;

endmodule

/* sv/hexapod_leg_phase_force_feedback_top.sv */
// Top level: delay ring, tap addressing, pipeline control and six leg units
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  tick    | in  | valid/ready        | cpg_sample, force_r0..r2, force_l0..l2
//  target  | out | valid/ready        | phase_r0..l2, height_r0..l2
//  cfg     | in  | cfg_we (no ready)  | cfg_index, cfg_wdata
//
//  Throughput: one item per cycle unless stalled. Path: stage one, leg registers.
//  Six ring copies each give one tap per cycle, so all six reads happen in the same cycle.
//  Reset: no clearing pass; a lap flag and the write pointer mark unwritten
//  entries, which read as zero. Items are accepted from the first cycle.
//  Stalls: a held result keeps the leg state; one more item waits in stage one.
`timescale 1ns / 1ps
`include "hexapod_leg_phase_force_feedback_top_macros.svh"

module hexapod_leg_phase_force_feedback_top (
    input  logic                            clk,
    input  logic                            rst_n,
    hlpff_in_if.sink                        tick,
    hlpff_out_if.source                     target,
    input  logic                            cfg_we,
    input  logic [hlpff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hlpff_pkg::DATA_W-1:0]    cfg_wdata
);
    import hlpff_pkg::*;

    // Configuration registers
    logic [LEG_DELAY_W-1:0]  leg_delay_reg;
    logic [SIDE_DELAY_W-1:0] side_delay_reg;
    q14_t                    force_low_reg;
    q14_t                    force_high_reg;

    // Ring write side
    logic [PTR_W-1:0] wp_reg;
    logic             wrapped_reg;

    // Pipeline control
    logic accept;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic s1_adv;

    // Stage one payload
    q14_t     fresh_reg;
    q14_t     force_reg [NUM_LEGS];
    tap_sel_t sel_reg   [NUM_LEGS];

    // Tap addressing
    logic [DLY_W-1:0]  delay    [NUM_LEGS];
    logic [SUM_W-1:0]  dfold    [NUM_LEGS];
    logic [PTR_W-1:0]  raddr    [NUM_LEGS];
    tap_sel_t          sel_next [NUM_LEGS];
    logic [KEEP_W-1:0] ram_q    [NUM_LEGS];
    logic [KEEP_W-1:0] keep;
    q14_t              force_in [NUM_LEGS];

    q14_t phase  [NUM_LEGS];
    q14_t height [NUM_LEGS];

    // Handshake: stage one takes an item when empty or when it moves on
    assign out_adv    = !out_valid_reg || target.ready;
    assign s1_adv     = s1_valid_reg && out_adv;
    assign tick.ready = !s1_valid_reg || out_adv;
    assign accept     = tick.valid && tick.ready;

    assign keep = tick.cpg_sample[KEEP_W-1:0];

    assign force_in[0] = tick.force_r0;
    assign force_in[1] = tick.force_r1;
    assign force_in[2] = tick.force_r2;
    assign force_in[3] = tick.force_l0;
    assign force_in[4] = tick.force_l1;
    assign force_in[5] = tick.force_l2;

    // Leg delays: R0 2L, R1 L, R2 0, L0 2L+S, L1 L+S, L2 S
    always_comb
    begin
        delay[0] = DLY_W'({leg_delay_reg, 1'b0});
        delay[1] = DLY_W'(leg_delay_reg);
        delay[2] = '0;
        delay[3] = DLY_W'({leg_delay_reg, 1'b0}) + DLY_W'(side_delay_reg);
        delay[4] = DLY_W'(leg_delay_reg) + DLY_W'(side_delay_reg);
        delay[5] = DLY_W'(side_delay_reg);
    end

    // Address each tap; zero delay bypasses the ring, unwritten entries read zero
    always_comb
    begin
        for (int i = 0; i < NUM_LEGS; i++)
        begin
            dfold[i]            = tap_fold(delay[i]);
            raddr[i]            = tap_index(wp_reg, dfold[i]);
            sel_next[i].bypass  = (dfold[i] == '0);
            sel_next[i].written = wrapped_reg || (raddr[i] < wp_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LEGS; g++)
        begin : g_leg
            hlpff_tap_ram u_ram (
                .clk   (clk),
                .we    (accept),
                .waddr (wp_reg),
                .wdata (keep),
                .re    (accept),
                .raddr (raddr[g]),
                .rdata (ram_q[g])
            );

            hlpff_leg u_leg (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (s1_adv),
                .sel        (sel_reg[g]),
                .ram_q      (ram_q[g]),
                .fresh      (fresh_reg),
                .force_in   (force_reg[g]),
                .force_low  (force_low_reg),
                .force_high (force_high_reg),
                .phase      (phase[g]),
                .height     (height[g])
            );
        end
    endgenerate

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leg_delay_reg  <= LEG_DELAY_RST;
            side_delay_reg <= SIDE_DELAY_RST;
            force_low_reg  <= FORCE_LOW_RST;
            force_high_reg <= FORCE_HIGH_RST;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_e'(cfg_index))
                    CFG_LEG_DELAY:  leg_delay_reg  <= cfg_wdata[LEG_DELAY_W-1:0];
                    CFG_SIDE_DELAY: side_delay_reg <= cfg_wdata[SIDE_DELAY_W-1:0];
                    CFG_FORCE_LOW:  force_low_reg  <= q14_t'(cfg_wdata);
                    CFG_FORCE_HIGH: force_high_reg <= q14_t'(cfg_wdata);
                endcase
            end

            // Advance the write pointer and note the first lap
            if (accept)
            begin
                if (wp_reg == PTR_W'(DELAY_DEPTH - 1))
                begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (target.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage one payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fresh_reg <= sext_sample(keep);
            for (int i = 0; i < NUM_LEGS; i++)
            begin
                force_reg[i] <= force_in[i];
                sel_reg[i]   <= sel_next[i];
            end
        end
    end

    assign target.valid     = out_valid_reg;
    assign target.phase_r0  = phase[0];
    assign target.phase_r1  = phase[1];
    assign target.phase_r2  = phase[2];
    assign target.phase_l0  = phase[3];
    assign target.phase_l1  = phase[4];
    assign target.phase_l2  = phase[5];
    assign target.height_r0 = height[0];
    assign target.height_r1 = height[1];
    assign target.height_r2 = height[2];
    assign target.height_l0 = height[3];
    assign target.height_l1 = height[4];
    assign target.height_l2 = height[5];

    `HLPFF_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_reg,
        "accepted item did not reach stage one")
    `HLPFF_ASSERT_NEXT(a_s1_moves_out, s1_adv, out_valid_reg,
        "stage one item did not reach the output")
    `HLPFF_ASSERT_NEXT(a_wp_step, accept,
        (wp_reg == (($past(wp_reg) == PTR_W'(DELAY_DEPTH - 1)) ? '0 : $past(wp_reg) + 1'b1)),
        "write pointer did not step by one")
    `HLPFF_ASSERT_NOW(a_lap_sticky, 1'b1, !$fell(wrapped_reg),
        "lap flag dropped without reset")
    `HLPFF_ASSERT_NEXT(a_hold_on_stall, (out_valid_reg && !target.ready),
        (out_valid_reg && $stable(height[0]) && $stable(phase[5])),
        "held result changed under stall")

endmodule
